// ===== rtl/tcg_pkg.sv =====
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared types, constants and colour functions for the terminal cell grid.
// ----------------------------------------------------------------------------
package tcg_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 64;

    // signed width for cursor arithmetic: -255 .. 510
    localparam int MV_W    = 11;
    // width holding an active size up to 256
    localparam int ACT_W   = 9;
    // width for row * MAX_COLS + col up to 256 * 256
    localparam int CALC_W  = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CHAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_FG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_BG   = 3'd4;

    localparam logic [7:0]  COLS_RST       = 8'd80;
    localparam logic [6:0]  ROWS_RST       = 7'd25;
    localparam logic [7:0]  BLANK_CHAR_RST = 8'd32;
    localparam logic [31:0] BLANK_FG_RST   = 32'hFFFF_FFFF;
    localparam logic [31:0] BLANK_BG_RST   = 32'hFF00_0000;
    localparam logic [31:0] CUR_FG_RST     = 32'hFFFF_FFFF;
    localparam logic [31:0] CUR_BG_RST     = 32'hFF00_0000;
    localparam logic [7:0]  NEWLINE        = 8'd10;
    localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;

    localparam logic [31:0] BASE_PALETTE [16] = '{
        32'hFF000000, 32'hFFAA0000, 32'hFF00AA00, 32'hFFAA5500,
        32'hFF0000AA, 32'hFFAA00AA, 32'hFF00AAAA, 32'hFFAAAAAA,
        32'hFF555555, 32'hFFFF5555, 32'hFF55FF55, 32'hFFFFFF55,
        32'hFF5555FF, 32'hFFFF55FF, 32'hFF55FFFF, 32'hFFFFFFFF
    };

    typedef enum logic [3:0] {
        MODE_PUT      = 4'd0,
        MODE_UP       = 4'd1,
        MODE_DOWN     = 4'd2,
        MODE_FWD      = 4'd3,
        MODE_BACK     = 4'd4,
        MODE_SETPOS   = 4'd5,
        MODE_FG16     = 4'd6,
        MODE_BG16     = 4'd7,
        MODE_FG256    = 4'd8,
        MODE_BG256    = 4'd9,
        MODE_FGRGB    = 4'd10,
        MODE_BGRGB    = 4'd11,
        MODE_RESET    = 4'd12,
        MODE_CLEAR    = 4'd13,
        MODE_CLEARROW = 4'd14,
        MODE_READ     = 4'd15
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic [31:0] fg;
        logic [31:0] bg;
    } cell_t;

    typedef struct packed {
        mode_t       mode;
        logic [7:0]  char_code;
        logic [7:0]  amount;
        logic [7:0]  row_sel;
        logic [7:0]  col_sel;
        logic [7:0]  color_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } cmd_t;

    typedef struct packed {
        logic [7:0] cols;
        logic [6:0] rows;
        cell_t      blank;
    } cfg_t;

    typedef struct packed {
        logic        fg_we;
        logic        bg_we;
        logic [31:0] fg;
        logic [31:0] bg;
    } color_upd_t;

    typedef struct packed {
        logic [5:0] row;
        logic [6:0] col;
        cell_t      cdata;
    } res_t;

    function automatic logic [31:0] pack_rgb(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        return {ALPHA_OPAQUE, r, g, b};
    endfunction

    // cube level: 0, or 40k + 55
    function automatic logic [7:0] cube_level(input logic [2:0] k);
        logic [7:0] lvl;
        lvl = (k == 3'd0) ? 8'd0 : 8'({5'd0, k} * 8'd40 + 8'd55);
        return lvl;
    endfunction

    function automatic logic [31:0] xterm_color(input logic [7:0] idx);
        logic [7:0]  v;
        logic [2:0]  qr;
        logic [2:0]  qg;
        logic [7:0]  rem;
        logic [7:0]  bl;
        logic [7:0]  gray;
        logic [31:0] col;
        v   = idx - 8'd16;
        qr  = (v >= 8'd180) ? 3'd5 : (v >= 8'd144) ? 3'd4 : (v >= 8'd108) ? 3'd3 :
              (v >= 8'd72)  ? 3'd2 : (v >= 8'd36)  ? 3'd1 : 3'd0;
        rem = v - 8'({5'd0, qr} * 8'd36);
        qg  = (rem >= 8'd30) ? 3'd5 : (rem >= 8'd24) ? 3'd4 : (rem >= 8'd18) ? 3'd3 :
              (rem >= 8'd12) ? 3'd2 : (rem >= 8'd6)  ? 3'd1 : 3'd0;
        bl  = rem - 8'({5'd0, qg} * 8'd6);
        gray = 8'((idx - 8'd232) * 8'd10 + 8'd8);
        if (idx < 8'd16)
        begin
            col = BASE_PALETTE[idx[3:0]];
        end
        else if (idx < 8'd232)
        begin
            col = pack_rgb(cube_level(qr), cube_level(qg), cube_level(bl[2:0]));
        end
        else
        begin
            col = pack_rgb(gray, gray, gray);
        end
        return col;
    endfunction

    function automatic logic [7:0] clamp_pos(input logic signed [MV_W-1:0] v,
                                             input logic [7:0] hi);
        logic [7:0] r;
        if (v < 0)
        begin
            r = 8'd0;
        end
        else if (v > $signed({{(MV_W-8){1'b0}}, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/tcg_cell_mem.sv =====
// ----------------------------------------------------------------------------
// tcg_cell_mem
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcg_cell_mem
    import tcg_pkg::*;
#(
    parameter int DEPTH = MAX_COLS_DEF * MAX_ROWS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  cell_t         wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output cell_t         rdata
);

    cell_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/tcg_color_unit.sv =====
// ----------------------------------------------------------------------------
// tcg_color_unit
// Decodes colour commands into foreground/background updates.
// ----------------------------------------------------------------------------
module tcg_color_unit
    import tcg_pkg::*;
(
    input  cmd_t       cmd,
    output color_upd_t upd
);

    logic [31:0] xcol;
    logic [31:0] rgb;
    logic [31:0] pal;
    logic        pal_ok;

    assign xcol   = xterm_color(cmd.color_index);
    assign rgb    = pack_rgb(cmd.red, cmd.green, cmd.blue);
    assign pal    = BASE_PALETTE[cmd.color_index[3:0]];
    assign pal_ok = (cmd.color_index < 8'd16);

    always_comb
    begin
        upd = '0;
        unique case (cmd.mode)
            MODE_FG16:
            begin
                upd.fg_we = pal_ok;
                upd.fg    = pal;
            end
            MODE_BG16:
            begin
                upd.bg_we = pal_ok;
                upd.bg    = pal;
            end
            MODE_FG256:
            begin
                upd.fg_we = 1'b1;
                upd.fg    = xcol;
            end
            MODE_BG256:
            begin
                upd.bg_we = 1'b1;
                upd.bg    = xcol;
            end
            MODE_FGRGB:
            begin
                upd.fg_we = 1'b1;
                upd.fg    = rgb;
            end
            MODE_BGRGB:
            begin
                upd.bg_we = 1'b1;
                upd.bg    = rgb;
            end
            MODE_RESET:
            begin
                upd.fg_we = 1'b1;
                upd.bg_we = 1'b1;
                upd.fg    = BASE_PALETTE[7];
                upd.bg    = BASE_PALETTE[0];
            end
            default:
            begin
                upd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/tcg_cmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcg_cmd_ctrl
// Command sequencer: cursor, current colours, clear sweeps and cell reads.
// ----------------------------------------------------------------------------
module tcg_cmd_ctrl
    import tcg_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_valid,
    output logic s_ready,
    input  cmd_t cmd,
    input  cfg_t cfg,
    input  logic cursor_home,
    input  logic out_free,
    output logic res_load,
    output res_t res
);

    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [31:0]       fg_reg, fg_next;
    logic [31:0]       bg_reg, bg_next;
    logic [AW-1:0]     sw_addr_reg, sw_addr_next;
    logic [AW-1:0]     sw_end_reg, sw_end_next;
    cell_t             fill_reg, fill_next;
    logic              rd_ok_reg, rd_ok_next;

    color_upd_t        upd;
    logic              accept;
    logic [ACT_W-1:0]  acols;
    logic [ACT_W-1:0]  arows;
    logic [7:0]        max_col;
    logic [7:0]        max_row;
    logic [7:0]        row8;
    logic [7:0]        col8;
    logic signed [MV_W-1:0] row_s;
    logic signed [MV_W-1:0] col_s;
    logic signed [MV_W-1:0] amt_s;
    logic signed [MV_W-1:0] rsel_s;
    logic signed [MV_W-1:0] csel_s;
    logic [CALC_W-1:0] put_addr;
    logic [CALC_W-1:0] rd_addr;
    logic [CALC_W-1:0] row_base;
    logic [CALC_W-1:0] row_last;
    logic              row_in;
    logic              col_in;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    cell_t             mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    cell_t             mem_rdata;

    tcg_color_unit u_color
    (
        .cmd (cmd),
        .upd (upd)
    );

    tcg_cell_mem #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE) && out_free;
    assign accept  = s_valid && s_ready;

    // active grid size, clamped to 1..MAX
    assign acols = (cfg.cols == 8'd0) ? ACT_W'(1) :
                   (ACT_W'(cfg.cols) > ACT_W'(MAX_COLS)) ? ACT_W'(MAX_COLS) : ACT_W'(cfg.cols);
    assign arows = (cfg.rows == 7'd0) ? ACT_W'(1) :
                   (ACT_W'(cfg.rows) > ACT_W'(MAX_ROWS)) ? ACT_W'(MAX_ROWS) : ACT_W'(cfg.rows);
    assign max_col = 8'(acols - ACT_W'(1));
    assign max_row = 8'(arows - ACT_W'(1));

    assign row8   = 8'(cur_row_reg);
    assign col8   = 8'(cur_col_reg);
    assign row_s  = $signed({{(MV_W-8){1'b0}}, row8});
    assign col_s  = $signed({{(MV_W-8){1'b0}}, col8});
    assign amt_s  = $signed({{(MV_W-8){1'b0}}, cmd.amount});
    assign rsel_s = $signed({{(MV_W-8){1'b0}}, cmd.row_sel});
    assign csel_s = $signed({{(MV_W-8){1'b0}}, cmd.col_sel});

    assign put_addr = CALC_W'(cur_row_reg) * CALC_W'(MAX_COLS) + CALC_W'(cur_col_reg);
    assign rd_addr  = CALC_W'(cmd.row_sel) * CALC_W'(MAX_COLS) + CALC_W'(cmd.col_sel);
    assign row_base = CALC_W'(cmd.row_sel) * CALC_W'(MAX_COLS);
    assign row_last = row_base + CALC_W'(acols) - CALC_W'(1);
    assign row_in   = (ACT_W'(cmd.row_sel) < arows);
    assign col_in   = (ACT_W'(cmd.col_sel) < acols);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // clearing pass over the whole store leaves reset
            state_reg   <= ST_SWEEP;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            fg_reg      <= CUR_FG_RST;
            bg_reg      <= CUR_BG_RST;
            sw_addr_reg <= '0;
            sw_end_reg  <= AW'(CELL_COUNT - 1);
            fill_reg    <= '{ch: BLANK_CHAR_RST, fg: BLANK_FG_RST, bg: BLANK_BG_RST};
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_row_reg <= cur_row_next;
            cur_col_reg <= cur_col_next;
            fg_reg      <= fg_next;
            bg_reg      <= bg_next;
            sw_addr_reg <= sw_addr_next;
            sw_end_reg  <= sw_end_next;
            fill_reg    <= fill_next;
            rd_ok_reg   <= rd_ok_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cur_row_next = cur_row_reg;
        cur_col_next = cur_col_reg;
        fg_next      = fg_reg;
        bg_next      = bg_reg;
        sw_addr_next = sw_addr_reg;
        sw_end_next  = sw_end_reg;
        fill_next    = fill_reg;
        rd_ok_next   = rd_ok_reg;
        mem_we       = 1'b0;
        mem_waddr    = sw_addr_reg;
        mem_wdata    = fill_reg;
        mem_re       = 1'b0;
        mem_raddr    = rd_addr[AW-1:0];
        res_load     = 1'b0;
        res          = '0;

        unique case (state_reg)
            ST_SWEEP:
            begin
                mem_we = 1'b1;
                if (sw_addr_reg == sw_end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sw_addr_next = sw_addr_reg + AW'(1);
                end
            end
            ST_READ:
            begin
                res_load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_load = (cmd.mode != MODE_READ);
                    if (upd.fg_we)
                    begin
                        fg_next = upd.fg;
                    end
                    if (upd.bg_we)
                    begin
                        bg_next = upd.bg;
                    end
                    unique case (cmd.mode) inside
                        MODE_PUT:
                        begin
                            if (cmd.char_code == NEWLINE)
                            begin
                                cur_row_next = ROW_W'(clamp_pos(row_s + MV_W'(1), max_row));
                                cur_col_next = '0;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = put_addr[AW-1:0];
                                mem_wdata = '{ch: cmd.char_code, fg: fg_reg, bg: bg_reg};
                                if (ACT_W'(col8) + ACT_W'(1) >= acols)
                                begin
                                    cur_col_next = '0;
                                    cur_row_next =
                                        ROW_W'(clamp_pos(row_s + MV_W'(1), max_row));
                                end
                                else
                                begin
                                    cur_col_next = cur_col_reg + COL_W'(1);
                                end
                            end
                        end
                        MODE_UP:
                        begin
                            cur_row_next = ROW_W'(clamp_pos(row_s - amt_s, max_row));
                        end
                        MODE_DOWN:
                        begin
                            cur_row_next = ROW_W'(clamp_pos(row_s + amt_s, max_row));
                        end
                        MODE_FWD:
                        begin
                            cur_col_next = COL_W'(clamp_pos(col_s + amt_s, max_col));
                        end
                        MODE_BACK:
                        begin
                            cur_col_next = COL_W'(clamp_pos(col_s - amt_s, max_col));
                        end
                        MODE_SETPOS:
                        begin
                            cur_row_next = ROW_W'(clamp_pos(rsel_s, max_row));
                            cur_col_next = COL_W'(clamp_pos(csel_s, max_col));
                        end
                        MODE_FG16, MODE_BG16, MODE_FG256, MODE_BG256,
                        MODE_FGRGB, MODE_BGRGB, MODE_RESET:
                        begin
                        end
                        MODE_CLEAR:
                        begin
                            sw_addr_next = '0;
                            sw_end_next  = AW'(CELL_COUNT - 1);
                            fill_next    = cfg.blank;
                            state_next   = ST_SWEEP;
                        end
                        MODE_CLEARROW:
                        begin
                            if (row_in)
                            begin
                                sw_addr_next = row_base[AW-1:0];
                                sw_end_next  = row_last[AW-1:0];
                                fill_next    = cfg.blank;
                                state_next   = ST_SWEEP;
                            end
                        end
                        MODE_READ:
                        begin
                            mem_re     = 1'b1;
                            rd_ok_next = row_in && col_in;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // size write homes the cursor
        if (cursor_home)
        begin
            cur_row_next = '0;
            cur_col_next = '0;
        end

        res.row = 6'(8'(cur_row_next));
        res.col = 7'(8'(cur_col_next));
        if ((state_reg == ST_READ) && rd_ok_reg)
        begin
            res.cdata = mem_rdata;
        end
    end

endmodule

// ===== rtl/terminal_cell_grid_engine.sv =====
// ----------------------------------------------------------------------------
// terminal_cell_grid_engine
// Text terminal cell store with cursor, colour state and clear/read commands.
// ----------------------------------------------------------------------------
// One command per transfer on the slave stream, one result per command on the
// master stream. Put, cursor moves and colour commands may follow back to back while
// results are taken; a read passes through a read state, set by the registered read
// port of the cell memory, and holds off further commands. Clear sweeps the whole
// store and clear row of a row in range sweeps its active columns, both through the
// single memory write port filling one cell a cycle. After reset a clearing pass over
// all MAX_COLS*MAX_ROWS cells (8192 at the default size) fills the store before the
// first command is taken; configuration writes are taken throughout. A new command
// is only taken when the result register is empty or its result leaves in that cycle,
// so a stalled result stream stalls the command stream.
module terminal_cell_grid_engine
    import tcg_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // char_code, amount, row_sel, col_sel, color_index, red, green, blue
    input  logic [63:0]           s_axis_tdata,
    // mode
    input  logic [3:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // cursor_row_out, cursor_col_out, cell_char, cell_fg, cell_bg, zero pad
    output logic [87:0]           m_axis_tdata
);

    logic [7:0]  cols_reg;
    logic [6:0]  rows_reg;
    logic [7:0]  blank_char_reg;
    logic [31:0] blank_fg_reg;
    logic [31:0] blank_bg_reg;
    logic        out_valid_reg, out_valid_next;
    res_t        out_data_reg;

    cfg_t  cfg;
    cmd_t  cmd;
    res_t  res;
    logic  res_load;
    logic  out_free;
    logic  cursor_home;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg       <= COLS_RST;
            rows_reg       <= ROWS_RST;
            blank_char_reg <= BLANK_CHAR_RST;
            blank_fg_reg   <= BLANK_FG_RST;
            blank_bg_reg   <= BLANK_BG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLS:       cols_reg       <= cfg_data[7:0];
                CFG_ROWS:       rows_reg       <= cfg_data[6:0];
                CFG_BLANK_CHAR: blank_char_reg <= cfg_data[7:0];
                CFG_BLANK_FG:   blank_fg_reg   <= cfg_data;
                CFG_BLANK_BG:   blank_bg_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cursor_home = cfg_we && ((cfg_index == CFG_COLS) || (cfg_index == CFG_ROWS));

    assign cfg = '{cols: cols_reg, rows: rows_reg,
                   blank: '{ch: blank_char_reg, fg: blank_fg_reg, bg: blank_bg_reg}};

    assign cmd = '{mode:        mode_t'(s_axis_tuser),
                   char_code:   s_axis_tdata[7:0],
                   amount:      s_axis_tdata[15:8],
                   row_sel:     s_axis_tdata[23:16],
                   col_sel:     s_axis_tdata[31:24],
                   color_index: s_axis_tdata[39:32],
                   red:         s_axis_tdata[47:40],
                   green:       s_axis_tdata[55:48],
                   blue:        s_axis_tdata[63:56]};

    assign out_free = !out_valid_reg || m_axis_tready;

    tcg_cmd_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_valid     (s_axis_tvalid),
        .s_ready     (s_axis_tready),
        .cmd         (cmd),
        .cfg         (cfg),
        .cursor_home (cursor_home),
        .out_free    (out_free),
        .res_load    (res_load),
        .res         (res)
    );

    assign out_valid_next = res_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg.cdata.bg, out_data_reg.cdata.fg,
                            out_data_reg.cdata.ch, out_data_reg.col, out_data_reg.row};

`ifndef SYNTHESIS
    // a transfer is only taken when the result slot can hold its result
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("command taken while result slot stalled");

    // every command other than a read presents its result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser != MODE_READ)) |=> m_axis_tvalid)
        else $error("result missing after command");

    // a read holds off further commands while in its read state, then shows its result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_READ))
            |=> (!s_axis_tready ##1 m_axis_tvalid))
        else $error("read sequencing broken");
`endif

endmodule
